@@ hdl/lrf_pkg.sv @@
// Package for the least rotation finder: sequencer states and field widths.
// No dependencies; imported by least_rotation_finder_top, lrf_rotation_checker and least_rotation_finder_top_test.
`default_nettype none

package lrf_pkg;

    // Field widths
    localparam int CH_W    = 8;
    localparam int SHIFT_W = 6;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 16;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CMP_RD,
        ST_CMP_EV,
        ST_OUT_RD,
        ST_OUT_SH
    } lrf_state_t;

endpackage

`default_nettype wire

@@ hdl/least_rotation_finder_top.sv @@
// Least rotation finder: loads a string, finds its least rotation with one
// shared signed byte comparator, then streams it out. Depends on lrf_pkg.
// Load: one beat per cycle. Search: a read state and a compare state per
// compared character, input not ready. Output: a read and a present state
// per beat, held while tready is low, a beat per stored character, then ready for a string.
// Reset clears the sequencer, count, overflow flag and best shift, not the character memory.
`default_nettype none

module least_rotation_finder_top #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [lrf_pkg::IN_W-1:0]  s_axis_tdata,  // [7:0] ch
    input  wire logic                      s_axis_tlast,  // last
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [lrf_pkg::OUT_W-1:0]      m_axis_tdata,  // [7:0] out_ch, [13:8] best_shift,
                                                          // [14] overflow, [15] zero
    output logic                           m_axis_tlast   // out_last
);

    import lrf_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);

    lrf_state_t state_reg, state_next;

    logic [CW-1:0]   cnt_reg, cnt_next;       // characters stored
    logic            dropped_reg, dropped_next;
    logic [AW-1:0]   s_reg, s_next;           // best shift so far
    logic [CW-1:0]   i_reg, i_next;           // candidate shift
    logic [AW-1:0]   a_reg, a_next;           // read pointer into best rotation
    logic [AW-1:0]   b_reg, b_next;           // read pointer into candidate
    logic [CW-1:0]   k_reg, k_next;           // characters compared / emitted

    logic [CH_W-1:0] mem [MAX_LEN];
    logic [CH_W-1:0] rd_a_reg, rd_b_reg;

    logic            in_beat, out_beat, full, wr_en;
    logic [CW-1:0]   n_eff, a_p1, b_p1, k_p1, i_p1;
    logic [AW-1:0]   a_wrap, b_wrap;
    logic            differ, cand_less, cmp_done, cand_done, out_end;
    logic [AW+SHIFT_W-1:0] shift_ext;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;
    assign full     = (cnt_reg == CW'(MAX_LEN));
    assign wr_en    = in_beat && !full;
    assign n_eff    = full ? cnt_reg : cnt_reg + CW'(1);

    // Wraparound pointer steps
    assign a_p1   = CW'(a_reg) + CW'(1);
    assign b_p1   = CW'(b_reg) + CW'(1);
    assign a_wrap = (a_p1 == cnt_reg) ? '0 : a_p1[AW-1:0];
    assign b_wrap = (b_p1 == cnt_reg) ? '0 : b_p1[AW-1:0];
    assign k_p1   = k_reg + CW'(1);
    assign i_p1   = i_reg + CW'(1);

    // Shared comparator
    assign differ    = (rd_a_reg != rd_b_reg);
    assign cand_less = ($signed(rd_b_reg) < $signed(rd_a_reg));
    assign cmp_done  = differ || (k_p1 == cnt_reg);
    assign cand_done = (i_p1 == cnt_reg);
    assign out_end   = (k_p1 == cnt_reg);

    // Character memory, two registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AW-1:0]] <= s_axis_tdata[CH_W-1:0];
        end
        rd_a_reg <= mem[a_reg];
        rd_b_reg <= mem[b_reg];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat && s_axis_tlast)
                begin
                    state_next = (n_eff == CW'(1)) ? ST_OUT_RD : ST_CMP_RD;
                end
            end
            ST_CMP_RD: state_next = ST_CMP_EV;
            ST_CMP_EV:
            begin
                if (cmp_done && cand_done)
                begin
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_CMP_RD;
                end
            end
            ST_OUT_RD: state_next = ST_OUT_SH;
            ST_OUT_SH:
            begin
                if (out_beat)
                begin
                    state_next = out_end ? ST_LOAD : ST_OUT_RD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        s_next       = s_reg;
        i_next       = i_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_beat)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (s_axis_tlast)
                    begin
                        s_next = '0;
                        i_next = CW'(1);
                        a_next = '0;
                        b_next = AW'(1);
                        k_next = '0;
                    end
                end
            end
            ST_CMP_EV:
            begin
                if (cmp_done)
                begin
                    // move to next candidate
                    if (differ && cand_less)
                    begin
                        s_next = i_reg[AW-1:0];
                    end
                    i_next = i_p1;
                    a_next = (differ && cand_less) ? i_reg[AW-1:0] : s_reg;
                    b_next = i_p1[AW-1:0];
                    k_next = '0;
                end
                else
                begin
                    a_next = a_wrap;
                    b_next = b_wrap;
                    k_next = k_p1;
                end
            end
            ST_OUT_SH:
            begin
                if (out_beat)
                begin
                    if (out_end)
                    begin
                        cnt_next     = '0;
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        a_next = a_wrap;
                        k_next = k_p1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            s_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            s_reg       <= s_next;
        end
    end

    // Loop registers, no reset needed
    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    // Outputs
    assign shift_ext     = {{SHIFT_W{1'b0}}, s_reg};
    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT_SH);
    assign m_axis_tlast  = out_end;
    assign m_axis_tdata  = {1'b0, dropped_reg, shift_ext[SHIFT_W-1:0], rd_a_reg};

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while a result is shown");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_LEN))
        else $error("character count beyond capacity");

    a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP_EV) |-> (CW'(s_reg) < cnt_reg))
        else $error("best shift outside stored string");

    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_axis_tlast) |=> (s_axis_tready && cnt_reg == '0 && !dropped_reg))
        else $error("not ready for a new string after the last beat");
`endif

endmodule

`default_nettype wire

@@ bench/lrf_rotation_checker.sv @@
// Checker for the least rotation finder: watches the character and result
// streams, predicts every result beat and compares it field by field.
// Depends on lrf_pkg; instantiated by least_rotation_finder_top_test.

module lrf_rotation_checker #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    input  wire logic                      s_axis_tready,
    input  wire logic [lrf_pkg::IN_W-1:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic                      s_axis_tlast,   // last
    input  wire logic                      m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    input  wire logic [lrf_pkg::OUT_W-1:0] m_axis_tdata,   // [7:0] out_ch, [13:8] best_shift,
                                                           // [14] overflow, [15] zero
    input  wire logic                      m_axis_tlast,   // out_last
    output int                             fail_count,
    output int                             beats_owed
);

    import lrf_pkg::*;

    // Bit positions of the result fields
    localparam int SHIFT_LO = CH_W;
    localparam int OVF_BIT  = CH_W + SHIFT_W;
    localparam int PAD_BIT  = OUT_W - 1;

    typedef struct {
        byte                ch;
        bit                 last;
        bit [SHIFT_W-1:0]   shift;
        bit                 overflow;
    } rot_beat_t;

    // Expected result beats, oldest first
    rot_beat_t rotation_q[$];

    // Predictor copy of the string buffer
    byte str_chars[MAX_LEN];
    int  str_len;
    bit  str_dropped;

    task automatic check_field(input string name, input logic signed [15:0] want_v,
                               input logic signed [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rot_beat_t want;
        int n;
        int best;
        int a;
        int b;
        int k;
        int pos;
        if (!rst_n)
        begin
            str_len     = 0;
            str_dropped = 1'b0;
            rotation_q.delete();
            fail_count  = 0;
            beats_owed <= 0;
        end
        else
        begin
            // Result beat: compare against the oldest expectation
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (rotation_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got tdata %h tlast %b",
                             $time, m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end
                else
                begin
                    want = rotation_q.pop_front();
                    check_field("out_ch", want.ch, $signed(m_axis_tdata[CH_W-1:0]));
                    check_field("best_shift", want.shift, m_axis_tdata[OVF_BIT-1:SHIFT_LO]);
                    check_field("overflow", want.overflow, m_axis_tdata[OVF_BIT]);
                    check_field("tdata pad", 0, m_axis_tdata[PAD_BIT]);
                    check_field("out_last", want.last, m_axis_tlast);
                end
            end

            // Character beat: store it, or note the drop once the buffer is full
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (str_len < MAX_LEN)
                begin
                    str_chars[str_len] = byte'(s_axis_tdata[CH_W-1:0]);
                    str_len++;
                end
                else
                    str_dropped = 1'b1;

                // Closing beat: find the least rotation, earliest shift on ties
                if (s_axis_tlast)
                begin
                    n    = str_len;
                    best = 0;
                    for (int c = 1; c < n; c++)
                    begin
                        a = best;
                        b = c;
                        k = 0;
                        while (k < n && str_chars[a] == str_chars[b])
                        begin
                            a = (a + 1 == n) ? 0 : a + 1;
                            b = (b + 1 == n) ? 0 : b + 1;
                            k++;
                        end
                        if (k < n && str_chars[b] < str_chars[a])
                            best = c;
                    end

                    pos = best;
                    for (int i = 0; i < n; i++)
                    begin
                        want.ch       = str_chars[pos];
                        want.last     = (i == n - 1);
                        want.shift    = best[SHIFT_W-1:0];
                        want.overflow = str_dropped;
                        rotation_q.push_back(want);
                        pos = (pos + 1 == n) ? 0 : pos + 1;
                    end
                    str_len     = 0;
                    str_dropped = 1'b0;
                end
            end

            beats_owed <= rotation_q.size();
        end
    end

endmodule

@@ bench/least_rotation_finder_top_test.sv @@
// Testbench top for the least rotation finder: clock, reset, string stimulus
// with random idling on both streams, watchdog and verdict.
// Depends on lrf_pkg, least_rotation_finder_top and lrf_rotation_checker.

module least_rotation_finder_top_test;

    import lrf_pkg::*;

    localparam int MAX_LEN     = 64;
    localparam int ITEM_GOAL   = 350;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 50000;
    localparam int DRAIN       = 300;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;    // [7:0] ch
    logic                s_axis_tlast;    // last
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;    // [7:0] out_ch, [13:8] best_shift, [14] overflow
    logic                m_axis_tlast;    // out_last

    int fail_total;
    int beats_owed;
    int items_sent = 0;
    int long_holds_asked = 0;

    always #10 clk = ~clk;

    least_rotation_finder_top #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    lrf_rotation_checker #(
        .MAX_LEN(MAX_LEN)
    ) rotation_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .fail_count(fail_total),
        .beats_owed(beats_owed)
    );

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Offer one string, one character per beat, tlast on the final one
    task automatic send_string(input byte chars[$], input bit steady);
        int gap;
        for (int i = 0; i < chars.size(); i++)
        begin
            gap = steady ? 0 : idle_len();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= chars[i];
            s_axis_tlast  <= (i == chars.size() - 1);
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            items_sent++;
        end
    endtask

    // Stop offering and wait until every predicted beat has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_owed != 0)
            @(posedge clk);
    endtask

    // Result side: random back-pressure, long open stretches, requested long holds
    initial
    begin : receiver
        int span;
        bit open;
        int holds_done;
        holds_done = 0;
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (holds_done < long_holds_asked)
            begin
                holds_done++;
                open = 1'b0;
                span = LONG_HOLD;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                open = 1'b1;
                span = $urandom_range(40, 150);
            end
            else
            begin
                open = ($urandom_range(0, 2) != 0);
                span = open ? $urandom_range(1, 6) : idle_len();
                if (span == 0)
                    span = 1;
            end
            m_axis_tready <= open;
            repeat (span) @(posedge clk);
        end
    end

    // Watchdog: too long without any beat on either stream
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Character stream: directed strings, then random ones
    initial
    begin : stimulus
        byte str_q[$];
        byte pat[$];
        byte va;
        byte vb;
        int  str_idx;
        int  len;
        int  mode;
        int  pick;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single character strings at both signed extremes
        str_q = '{8'h7f};
        send_string(str_q, 1'b0);
        str_q = '{8'h80};
        send_string(str_q, 1'b0);
        // Newline and zero as data; periodic string, tie keeps the earlier shift
        str_q = '{8'h0a, 8'h00, 8'h0a, 8'h00};
        send_string(str_q, 1'b0);
        // Signed order: 0x80 sorts below 0x7f and 0x01
        str_q = '{8'h7f, 8'h80, 8'h01};
        send_string(str_q, 1'b1);
        // Winner decided only after wraparound
        str_q = '{8'hff, 8'h00, 8'hff, 8'h00, 8'hff};
        send_string(str_q, 1'b0);
        // Alternating bit patterns
        str_q = '{8'h55, 8'haa, 8'h00, 8'hff};
        send_string(str_q, 1'b0);
        wait_drained();

        // Random strings: first a full buffer, then an overflowing one
        str_idx = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (str_idx == 0)
                len = MAX_LEN;
            else if (str_idx == 1)
                len = MAX_LEN + 2;
            else
            begin
                pick = $urandom_range(0, 29);
                if (pick == 0)
                    len = MAX_LEN;
                else if (pick == 1)
                    len = $urandom_range(MAX_LEN + 1, MAX_LEN + 8);
                else
                    len = $urandom_range(1, 12);
            end

            // Content: full range, two symbols, or a repeated pattern for ties
            mode = $urandom_range(0, 2);
            va   = byte'($urandom_range(0, 255));
            vb   = byte'($urandom_range(0, 255));
            pat.delete();
            repeat ($urandom_range(1, 3)) pat.push_back(byte'($urandom_range(0, 255)));
            str_q.delete();
            for (int i = 0; i < len; i++)
            begin
                case (mode)
                    0:       str_q.push_back(byte'($urandom_range(0, 255)));
                    1:       str_q.push_back($urandom_range(0, 1) ? va : vb);
                    default: str_q.push_back(pat[i % pat.size()]);
                endcase
            end

            // Long receiver hold while strings keep coming, so the input stalls
            if (str_idx == 4)
                long_holds_asked++;
            send_string(str_q, (str_idx >= 4 && str_idx < 8) || $urandom_range(0, 4) == 0);
            if (str_idx == 20)
                wait_drained();
            str_idx++;
        end

        wait_drained();
        repeat (DRAIN) @(posedge clk);
        if (fail_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
